[src/cprt_pkg.sv]
// ----------------------------------------------------------------------------
// cprt_pkg
// Types and constants for the clock page replacement frame table.
// ----------------------------------------------------------------------------
package cprt_pkg;

	localparam int NumFrames    = 16;
	localparam int PinCountBits = 8;
	localparam int FrameBits    = $clog2(NumFrames);
	localparam int PageBits     = 16;
	localparam int CfgBits      = 5;

	typedef logic [2:0] func_t;
	localparam func_t FuncRequest  = 3'd0;
	localparam func_t FuncPinDown  = 3'd1;
	localparam func_t FuncPinUp    = 3'd2;
	localparam func_t FuncSetPin   = 3'd3;
	localparam func_t FuncClearPin = 3'd4;
	localparam func_t FuncDirty    = 3'd5;

	typedef logic [2:0] status_t;
	localparam status_t StHit      = 3'd0;
	localparam status_t StFilled   = 3'd1;
	localparam status_t StClean    = 3'd2;
	localparam status_t StDirty    = 3'd3;
	localparam status_t StNoVictim = 3'd4;
	localparam status_t StAbsent   = 3'd5;
	localparam status_t StDone     = 3'd6;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] page_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  frame_index;
		logic [15:0] victim_page;
	} rsp_t;

	// one frame entry as held in memory
	typedef struct packed {
		logic [PageBits-1:0]     page;
		logic                    dirty;
		logic [PinCountBits-1:0] pin_count;
		logic                    reference;
		logic                    pinned;
	} entry_t;

endpackage

[src/clock_page_replacement_table_top.sv]
// Flow: an unused func or page 0 is answered directly; any other item scans the n
//   frames in use for its page; a missed request then looks for a free frame and,
//   if none, sweeps for a second-chance victim (n = frames in use).
// One item at a time: the next beat is taken only after the result has been
//   accepted by a ready receiver.
// Reset: control state and frame valid bits clear at once, so frames read empty;
//   the frames-in-use setting cfg_q returns to 16.
// ----------------------------------------------------------------------------
// clock_page_replacement_table_top
// Frame table with lookup, free-frame fill, second-chance eviction and pin/dirty updates.
// ----------------------------------------------------------------------------
module clock_page_replacement_table_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cprt_pkg::req_t        in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cprt_pkg::rsp_t        out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [4:0]            cfg_data
);
	import cprt_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOOK  = 7'b0000010,
		S_FREE  = 7'b0000100,
		S_SWEEP = 7'b0001000,
		S_WB    = 7'b0010000,
		S_OUT   = 7'b0100000,
		S_DECIDE= 7'b1000000
	} state_t;

	localparam int CntBits = FrameBits + 2;

	state_t               state_q;
	entry_t               mem [NumFrames];
	logic [NumFrames-1:0] valid_q;
	entry_t               rd_q;
	logic                 rd_vld_q;
	logic [FrameBits-1:0] rd_idx_q;
	logic [FrameBits-1:0] addr_q;
	logic [CntBits-1:0]   cnt_q;
	logic [FrameBits-1:0] hand_q;
	logic [CfgBits-1:0]   cfg_q;
	req_t                 req_q;
	rsp_t                 rsp_q;
	logic                 out_vld_q;
	logic                 wr_en;
	logic [FrameBits-1:0] wr_idx;
	entry_t               wr_data;
	entry_t               cur;
	logic [CntBits-1:0]   n;
	logic [FrameBits-1:0] last;
	logic [FrameBits-1:0] hand_nx;
	logic                 wr_fwd;
	localparam logic [PinCountBits-1:0] PinMax = '1;

	always_comb begin
		if (cfg_q == '0) n = CntBits'(1);
		else if (CntBits'(cfg_q) > CntBits'(NumFrames)) n = CntBits'(NumFrames);
		else n = CntBits'(cfg_q);
	end
	assign last    = FrameBits'(n - CntBits'(1));
	assign hand_nx = (rd_idx_q == last) ? '0 : rd_idx_q + FrameBits'(1);
	assign cur     = rd_vld_q ? rd_q : '0;
	// write and read of the same frame in one cycle: pass the new entry through
	assign wr_fwd  = wr_en && (wr_idx == addr_q);

	assign in_ready  = (state_q == S_IDLE) && !out_vld_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_vld_q;
	assign out_data  = rsp_q;

	// frame memory with one write port and one read port, read registered
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		rd_q <= wr_fwd ? wr_data : mem[addr_q];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = rd_idx_q;
		wr_data = cur;
		case (state_q)
			S_DECIDE: begin
				if (cnt_q != '0) begin
					wr_en = 1'b1;
					if (req_q.func == FuncRequest) begin
						wr_data.reference = 1'b1;
						if (cur.pin_count != PinMax)
							wr_data.pin_count = cur.pin_count + PinCountBits'(1);
					end else begin
						case (req_q.func)
							FuncPinDown: begin
								if (cur.pin_count != '0)
									wr_data.pin_count = cur.pin_count - PinCountBits'(1);
							end
							FuncPinUp: begin
								if (cur.pin_count != PinMax)
									wr_data.pin_count = cur.pin_count + PinCountBits'(1);
							end
							FuncSetPin:   wr_data.pinned = 1'b1;
							FuncClearPin: wr_data.pinned = 1'b0;
							default:      wr_data.dirty = ~cur.dirty;
						endcase
					end
				end
			end
			S_FREE, S_WB: begin
				wr_en   = (state_q == S_WB) || (cnt_q != '0 && cur.page == '0);
				if (state_q == S_WB) wr_idx = FrameBits'(rsp_q.frame_index);
				wr_data = '{page: req_q.page_id, dirty: 1'b0,
					pin_count: PinCountBits'(1), reference: 1'b1, pinned: 1'b0};
			end
			S_SWEEP: begin
				if (cnt_q != '0 && !cur.pinned && cur.pin_count == '0 && cur.reference) begin
					wr_en = 1'b1;
					wr_data.reference = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// LOOK: scan addresses 0..n-1, data for an address arrives in the following cycle at rd_idx_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			rd_vld_q  <= 1'b0;
			rd_idx_q  <= '0;
			addr_q    <= '0;
			cnt_q     <= '0;
			hand_q    <= '0;
			cfg_q     <= CfgBits'(NumFrames);
			out_vld_q <= 1'b0;
			req_q     <= '0;
			rsp_q     <= '0;
		end else begin
			rd_vld_q <= valid_q[addr_q] || wr_fwd;
			rd_idx_q <= addr_q;
			if (wr_en) valid_q[wr_idx] <= 1'b1;
			if (out_vld_q && out_ready) out_vld_q <= 1'b0;
			if (cfg_valid) cfg_q <= cfg_data;
			case (state_q)
				S_IDLE: begin
					addr_q <= '0;
					cnt_q  <= '0;
					if (in_valid && in_ready) begin
						req_q <= in_data;
						if (in_data.func > FuncDirty) begin
							rsp_q <= '{status: StDone, frame_index: '0, victim_page: '0};
							state_q <= S_OUT;
						end else if (in_data.page_id == '0) begin
							rsp_q <= '{status: StAbsent, frame_index: '0, victim_page: '0};
							state_q <= S_OUT;
						end else begin
							addr_q  <= FrameBits'(1);
							cnt_q   <= CntBits'(1);
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					// rd_idx_q holds frame cnt_q-1
					if (cur.page == req_q.page_id) begin
						rsp_q.frame_index <= 4'(rd_idx_q);
						rsp_q.victim_page <= '0;
						rsp_q.status <= (req_q.func == FuncRequest) ? StHit : StDone;
						addr_q  <= rd_idx_q;
						state_q <= S_DECIDE;
						cnt_q   <= '0;
					end else if (cnt_q == n) begin
						if (req_q.func != FuncRequest) begin
							rsp_q <= '{status: StAbsent, frame_index: '0, victim_page: '0};
							state_q <= S_OUT;
						end else begin
							addr_q  <= '0;
							cnt_q   <= '0;
							state_q <= S_FREE;
						end
					end else begin
						addr_q <= addr_q + FrameBits'(1);
						cnt_q  <= cnt_q + CntBits'(1);
					end
				end
				S_DECIDE: begin
					// the first DECIDE step re-reads the hit frame; the update is written in the step after it
					if (cnt_q == '0) cnt_q <= CntBits'(1);
					state_q <= (cnt_q == '0) ? S_DECIDE : S_OUT;
				end
				S_FREE: begin
					// the cnt_q == 0 step only primes the read of frame 0
					if (cnt_q == '0) begin
						addr_q <= FrameBits'(1);
						cnt_q  <= CntBits'(1);
					end else if (cur.page == '0) begin
						rsp_q <= '{status: StFilled, frame_index: 4'(rd_idx_q), victim_page: '0};
						state_q <= S_OUT;
					end else if (cnt_q == n) begin
						addr_q  <= (CntBits'(hand_q) >= n) ? '0 : hand_q;
						cnt_q   <= '0;
						state_q <= S_SWEEP;
					end else begin
						addr_q <= addr_q + FrameBits'(1);
						cnt_q  <= cnt_q + CntBits'(1);
					end
				end
				S_SWEEP: begin
					// first beat only primes the read
					if (cnt_q == '0) begin
						addr_q <= (addr_q == last) ? '0 : addr_q + FrameBits'(1);
						cnt_q  <= CntBits'(1);
					end else begin
						hand_q <= hand_nx;
						if (!cur.pinned && cur.pin_count == '0 && !cur.reference) begin
							rsp_q <= '{status: cur.dirty ? StDirty : StClean,
								frame_index: 4'(rd_idx_q), victim_page: cur.page};
							state_q <= S_WB;
						end else if ({1'b0, cnt_q} == {n, 1'b0}) begin
							rsp_q <= '{status: StNoVictim, frame_index: '0, victim_page: '0};
							state_q <= S_OUT;
						end else begin
							addr_q <= (addr_q == last) ? '0 : addr_q + FrameBits'(1);
							cnt_q  <= cnt_q + CntBits'(1);
						end
					end
				end
				S_WB: state_q <= S_OUT;
				S_OUT: begin
					out_vld_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !in_ready)
		else $error("input taken while beat pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |-> (rsp_q.status == StClean || rsp_q.status == StDirty))
		else $error("eviction without evict status");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready) |=> $stable(rsp_q))
		else $error("result changed while stalled");
endmodule
